// File: rtl/vector3_normalize_top_defines.svh
// Assertion macros used by the normalizer top level.
`ifndef VECTOR3_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR3_NORMALIZE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define NRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define NRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRM_ASSERT(lbl, clk, rst_n, prop, msg)
`define NRM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/nrm_pkg.sv
package nrm_pkg;

  // Default input component width.
  localparam int IN_WIDTH_DEF = 16;
  // Default fraction bits of the unit vector.
  localparam int OUT_FRAC_DEF = 14;
  // Fraction bits of the vector length.
  localparam int LEN_FRAC = 8;
  // Width of each normalized output word.
  localparam int OUT_W = 16;

  // Sideband that travels with each item through the pipeline.
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] sign;
  } nrm_side_t;

endpackage

// File: rtl/nrm_if.sv
// Input vector channel.
interface nrm_in_if #(parameter int IN_WIDTH = nrm_pkg::IN_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic [IN_WIDTH-1:0] vec_x;
  logic [IN_WIDTH-1:0] vec_y;
  logic [IN_WIDTH-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// Unit vector result channel.
interface nrm_out_if;
  logic                       valid;
  logic                       ready;
  logic [nrm_pkg::OUT_W-1:0]  unit_x;
  logic [nrm_pkg::OUT_W-1:0]  unit_y;
  logic [nrm_pkg::OUT_W-1:0]  unit_z;
  logic                       zero_length;

  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output zero_length, input ready);
  modport sink (input valid, input unit_x, input unit_y, input unit_z,
                input zero_length, output ready);
endinterface

// File: rtl/nrm_sqrt.sv
// Pipelined digit-by-digit square root of s * 2^(2*LEN_FRAC), one root bit per stage.
module nrm_sqrt #(
  parameter int IN_WIDTH = nrm_pkg::IN_WIDTH_DEF,
  parameter int PASS_W   = 3 * nrm_pkg::IN_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic [2*IN_WIDTH-1:0]                  s_i,
  input  nrm_pkg::nrm_side_t                     side_i,
  input  logic [PASS_W-1:0]                      pass_i,
  output logic [IN_WIDTH+nrm_pkg::LEN_FRAC-1:0]  root_o,
  output nrm_pkg::nrm_side_t                     side_o,
  output logic [PASS_W-1:0]                      pass_o
);

  localparam int SW = 2 * IN_WIDTH;
  localparam int RB = IN_WIDTH + nrm_pkg::LEN_FRAC;
  localparam int RW = RB + 3;

  logic [SW-1:0]      s_r    [RB];
  logic [RW-1:0]      rem_r  [RB];
  logic [RB-1:0]      root_r [RB];
  nrm_pkg::nrm_side_t side_r [RB];
  logic [PASS_W-1:0]  pass_r [RB];

  genvar k;
  for (k = 0; k < RB; k++) begin : g_step
    localparam int I = RB - 1 - k;
    logic [SW-1:0]      s_in;
    logic [RW-1:0]      rem_in;
    logic [RB-1:0]      root_in;
    nrm_pkg::nrm_side_t side_in;
    logic [PASS_W-1:0]  pass_in;
    logic [1:0]         pair;
    logic [RW-1:0]      tmp;
    logic [RW-1:0]      trial;
    logic [RW-1:0]      rem_nxt;
    logic [RB-1:0]      root_nxt;

    // Pick the stage input
    if (k == 0) begin : g_first
      assign s_in    = s_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign pass_in = pass_i;
    end else begin : g_next
      assign s_in    = s_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
      assign pass_in = pass_r[k-1];
    end

    // Bring down the next pair of radicand bits; the low pairs are zero fraction bits
    if (I >= nrm_pkg::LEN_FRAC) begin : g_pair
      assign pair = s_in[2*(I-nrm_pkg::LEN_FRAC)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    // Try subtracting 4*root+1
    always_comb begin
      tmp   = {rem_in[RW-3:0], pair};
      trial = {1'b0, root_in, 2'b01};
      if (tmp >= trial) begin
        rem_nxt  = tmp - trial;
        root_nxt = {root_in[RB-2:0], 1'b1};
      end else begin
        rem_nxt  = tmp;
        root_nxt = {root_in[RB-2:0], 1'b0};
      end
    end

    // Advance the stage when the pipeline moves
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].valid <= 1'b0;
      end else if (en) begin
        s_r[k]    <= s_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
        pass_r[k] <= pass_in;
      end
    end
  end

  assign root_o = root_r[RB-1];
  assign side_o = side_r[RB-1];
  assign pass_o = pass_r[RB-1];

endmodule

// File: rtl/nrm_div.sv
// Three pipelined restoring dividers, one quotient bit per stage:
// q = floor(a * 2^(OUT_FRAC_BITS+LEN_FRAC) / len), with a * 2^LEN_FRAC <= len.
module nrm_div #(
  parameter int IN_WIDTH      = nrm_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = nrm_pkg::OUT_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic [3*IN_WIDTH-1:0]                  mag_i,
  input  logic [IN_WIDTH+nrm_pkg::LEN_FRAC-1:0]  len_i,
  input  nrm_pkg::nrm_side_t                     side_i,
  output logic [3*(OUT_FRAC_BITS+1)-1:0]         q_o,
  output nrm_pkg::nrm_side_t                     side_o
);

  localparam int RB = IN_WIDTH + nrm_pkg::LEN_FRAC;
  localparam int DW = RB + 1;
  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NS = OUT_FRAC_BITS + 1;

  logic [DW-1:0]      r_r    [3][NS];
  logic [QW-1:0]      q_r    [3][NS];
  logic [RB-1:0]      len_r  [NS];
  nrm_pkg::nrm_side_t side_r [NS];

  genvar k, l;
  for (k = 0; k < NS; k++) begin : g_step
    logic [RB-1:0]      len_in;
    nrm_pkg::nrm_side_t side_in;

    if (k == 0) begin : g_first
      assign len_in  = len_i;
      assign side_in = side_i;
    end else begin : g_next
      assign len_in  = len_r[k-1];
      assign side_in = side_r[k-1];
    end

    for (l = 0; l < 3; l++) begin : g_lane
      logic [DW-1:0] r_in;
      logic [QW-1:0] q_in;
      logic [DW-1:0] r_nxt;
      logic [QW-1:0] q_nxt;
      logic          ge;

      // First step starts from a * 2^LEN_FRAC, later steps shift the remainder
      if (k == 0) begin : g_first
        assign r_in = {1'b0, mag_i[l*IN_WIDTH +: IN_WIDTH], {nrm_pkg::LEN_FRAC{1'b0}}};
        assign q_in = '0;
      end else begin : g_next
        assign r_in = {r_r[l][k-1][RB-1:0], 1'b0};
        assign q_in = q_r[l][k-1];
      end

      // Subtract the length where it fits
      always_comb begin
        ge    = (r_in >= {1'b0, len_in});
        r_nxt = ge ? (r_in - {1'b0, len_in}) : r_in;
        q_nxt = {q_in[QW-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          r_r[l][k] <= r_nxt;
          q_r[l][k] <= q_nxt;
        end
      end
    end

    // Advance length and sideband with the lanes
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].valid <= 1'b0;
      end else if (en) begin
        len_r[k]  <= len_in;
        side_r[k] <= side_in;
      end
    end
  end

  for (l = 0; l < 3; l++) begin : g_out
    assign q_o[l*QW +: QW] = q_r[l][NS-1];
  end
  assign side_o = side_r[NS-1];

endmodule

// File: rtl/vector3_normalize_top.sv
// Pipeline from accepted item to result:
//   square, sum, one stage per root bit, one stage per quotient bit, output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits at out_ch.
// Reset: synchronous active-low rst_n clears all valid bits; payload registers keep contents.
`include "vector3_normalize_top_defines.svh"

module vector3_normalize_top #(
  parameter int IN_WIDTH      = nrm_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = nrm_pkg::OUT_FRAC_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nrm_in_if.sink    in_ch,
  nrm_out_if.source out_ch
);

  localparam int W   = IN_WIDTH;
  localparam int SW  = 2 * W;
  localparam int RB  = W + nrm_pkg::LEN_FRAC;
  localparam int QW  = OUT_FRAC_BITS + 1;
  localparam int EXT = (QW + 1 > nrm_pkg::OUT_W) ? QW + 1 : nrm_pkg::OUT_W;
  localparam logic [QW-1:0] LIM = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  logic               en;
  logic [W-1:0]       comp   [3];
  logic [W-1:0]       mag_c  [3];
  logic [W-1:0]       mag1_r [3];
  logic [SW-1:0]      sq1_r  [3];
  nrm_pkg::nrm_side_t side1_nxt;
  nrm_pkg::nrm_side_t side1_r;
  logic [3*W-1:0]     mag2_r;
  logic [SW-1:0]      sum2_r;
  nrm_pkg::nrm_side_t side2_r;
  logic [RB-1:0]      len;
  logic [3*W-1:0]     mag3;
  nrm_pkg::nrm_side_t side3;
  logic [3*QW-1:0]    quot;
  nrm_pkg::nrm_side_t side4;
  logic [nrm_pkg::OUT_W-1:0] unit_nxt [3];
  logic [nrm_pkg::OUT_W-1:0] unit_r   [3];
  logic                      zero_r;
  logic                      valid_r;

  // Move the pipeline unless a result is stuck at the output
  assign en          = !valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign comp[0] = in_ch.vec_x;
  assign comp[1] = in_ch.vec_y;
  assign comp[2] = in_ch.vec_z;

  // Take magnitudes of the components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = comp[i][W-1] ? (~comp[i] + 1'b1) : comp[i];
    end
    side1_nxt.valid = in_ch.valid;
    side1_nxt.zero  = (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
    side1_nxt.sign  = {comp[2][W-1], comp[1][W-1], comp[0][W-1]};
  end

  // Stage 1: square each magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= mag_c[i];
        sq1_r[i]  <= mag_c[i] * mag_c[i];
      end
      side1_r <= side1_nxt;
    end
  end

  // Stage 2: sum the squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.valid <= 1'b0;
    end else if (en) begin
      sum2_r  <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      mag2_r  <= {mag1_r[2], mag1_r[1], mag1_r[0]};
      side2_r <= side1_r;
    end
  end

  nrm_sqrt #(
    .IN_WIDTH (W),
    .PASS_W   (3 * W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .s_i    (sum2_r),
    .side_i (side2_r),
    .pass_i (mag2_r),
    .root_o (len),
    .side_o (side3),
    .pass_o (mag3)
  );

  nrm_div #(
    .IN_WIDTH      (W),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .mag_i  (mag3),
    .len_i  (len),
    .side_i (side3),
    .q_o    (quot),
    .side_o (side4)
  );

  // Clamp, restore the sign and force zero for a zero vector
  always_comb begin
    logic [QW-1:0]  qv;
    logic [EXT-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      qv  = quot[i*QW +: QW];
      if (qv > LIM) begin
        qv = LIM;
      end
      ext = {{(EXT-QW){1'b0}}, qv};
      if (side4.sign[i]) begin
        ext = ~ext + 1'b1;
      end
      unit_nxt[i] = side4.zero ? '0 : ext[nrm_pkg::OUT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= side4.valid;
      zero_r  <= side4.zero;
      for (int i = 0; i < 3; i++) begin
        unit_r[i] <= unit_nxt[i];
      end
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.unit_x      = unit_r[0];
  assign out_ch.unit_y      = unit_r[1];
  assign out_ch.unit_z      = unit_r[2];
  assign out_ch.zero_length = zero_r;

  `NRM_ASSERT(a_zero_out, clk, rst_n, valid_r && zero_r |-> (unit_r[0] == '0) && (unit_r[1] == '0) && (unit_r[2] == '0), "zero vector gave nonzero output")
  `NRM_ASSERT(a_accept_st1, clk, rst_n, in_ch.valid && in_ch.ready |=> side1_r.valid, "accepted item missing from first stage")
  `NRM_ASSERT(a_zero_sum, clk, rst_n, en && side1_r.valid |=> (side2_r.zero == (sum2_r == '0)), "zero flag disagrees with sum of squares")
  `NRM_ASSERT(a_stall_hold, clk, rst_n, !en |=> $stable(sum2_r) && $stable(side2_r), "pipeline moved during stall")

endmodule
